// File: design/wifi_mgmt_frame_builder_defines.svh
// Assertion helpers for the management frame builder.
// Both sample on clk and are switched off while rst is high.
`ifndef WIFI_MGMT_FRAME_BUILDER_DEFINES_SVH
`define WIFI_MGMT_FRAME_BUILDER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define WMFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WMFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wmfb_pkg.sv
`timescale 1ns / 1ps

package wmfb_pkg;

  // Sizes
  localparam int MAX_SSID_BYTES = 32;
  localparam int SSID_LEN_W     = 6;
  localparam int HEAD_BYTES     = 38;
  localparam int TAIL_BYTES     = 29;
  localparam int CNT_W          = 6;
  localparam int IDX_W          = 7;

  // Item selector codes
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SSID   = 2'd1,
    FUNC_FINISH = 2'd2
  } func_t;

  // Register indexes
  localparam logic [1:0] CFG_STATION   = 2'd0;
  localparam logic [1:0] CFG_TIMESTAMP = 2'd1;
  localparam logic [1:0] CFG_CHANNEL   = 2'd2;

  // Build phase of the front end
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SSID = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  // Work handed to the back end
  typedef enum logic [1:0] {
    OP_HEAD = 2'd0,
    OP_SSID = 2'd1,
    OP_TAIL = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  kind;
    logic [47:0]           rx;
    logic [15:0]           seq;
    logic [SSID_LEN_W-1:0] len;
    logic [7:0]            data;
    logic [IDX_W-1:0]      base;
  } cmd_t;

  // Header byte positions
  localparam int POS_RX       = 4;
  localparam int POS_SA       = 10;
  localparam int POS_BSSID    = 16;
  localparam int POS_SEQ_LO   = 22;
  localparam int POS_SEQ_HI   = 23;
  localparam int POS_TS       = 24;
  localparam int POS_BI       = 32;
  localparam int POS_CAP      = 34;
  localparam int POS_SSID_LEN = 37;

  localparam int HEAD_LAST      = HEAD_BYTES - 1;
  localparam int TAIL_LAST      = TAIL_BYTES - 1;
  localparam int DS_CHANNEL_POS = 12;

  // Header constants
  localparam logic [7:0] FT_PROBE_RESP   = 8'h50;
  localparam logic [7:0] FT_BEACON       = 8'h80;
  localparam logic [7:0] BEACON_INTERVAL = 8'h64;
  localparam logic [7:0] CAPABILITY      = 8'h01;
  localparam logic [7:0] CHANNEL_RESET   = 8'h04;

  // Fixed trailing tags: rates, DS parameter, two ERP entries, extended rates
  localparam logic [7:0] TAIL_TAGS [TAIL_BYTES] = '{
    8'h01, 8'h08, 8'h02, 8'h04, 8'h0b, 8'h16, 8'h24, 8'h30, 8'h48, 8'h6c,
    8'h03, 8'h01, 8'h00,
    8'h2a, 8'h01, 8'h04, 8'h2f, 8'h01, 8'h04,
    8'h32, 8'h08, 8'h0c, 8'h12, 8'h18, 8'h24, 8'h30, 8'h48, 8'h60, 8'h6c
  };

  function automatic logic [7:0] tail_byte(input logic [4:0] pos,
                                           input logic [7:0] channel);
    logic [7:0] b;
    b = 8'h00;
    if (pos == 5'(DS_CHANNEL_POS)) begin
      b = channel;
    end else if (pos < 5'(TAIL_BYTES)) begin
      b = TAIL_TAGS[pos];
    end
    return b;
  endfunction

endpackage

// File: design/wmfb_front.sv
`timescale 1ns / 1ps

// Takes requests, tracks the frame phase and queues the work they call for
module wmfb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  logic [1:0]                     func,
  input  logic                           frame_kind,
  input  logic [47:0]                    receiver_address,
  input  logic [15:0]                    sequence_value,
  input  logic [wmfb_pkg::SSID_LEN_W-1:0] ssid_length,
  input  logic [7:0]                     ssid_byte,
  output logic                           push,
  output wmfb_pkg::cmd_t                 cmd
);

  wmfb_pkg::phase_t                  phase, phase_next;
  logic [wmfb_pkg::SSID_LEN_W-1:0]   remaining, remaining_next;
  logic [wmfb_pkg::SSID_LEN_W-1:0]   total, total_next;
  logic [wmfb_pkg::SSID_LEN_W-1:0]   len_sat;
  logic                              is_start, is_ssid, is_finish;

  // Long lengths saturate
  assign len_sat = (ssid_length > wmfb_pkg::SSID_LEN_W'(wmfb_pkg::MAX_SSID_BYTES)) ?
                   wmfb_pkg::SSID_LEN_W'(wmfb_pkg::MAX_SSID_BYTES) : ssid_length;

  // Classify against the current phase; anything out of order is dropped
  always_comb begin
    is_start  = 1'b0;
    is_ssid   = 1'b0;
    is_finish = 1'b0;
    case (func)
      wmfb_pkg::FUNC_START:  is_start  = (phase == wmfb_pkg::PH_IDLE);
      wmfb_pkg::FUNC_SSID:   is_ssid   = (phase == wmfb_pkg::PH_SSID) && (remaining != '0);
      wmfb_pkg::FUNC_FINISH: is_finish = (phase == wmfb_pkg::PH_TAIL);
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    total_next     = total;
    if (take) begin
      if (is_start) begin
        total_next     = len_sat;
        remaining_next = len_sat;
        phase_next     = (len_sat == '0) ? wmfb_pkg::PH_TAIL : wmfb_pkg::PH_SSID;
      end else if (is_ssid) begin
        remaining_next = remaining - 1'b1;
        if (remaining == wmfb_pkg::SSID_LEN_W'(1)) begin
          phase_next = wmfb_pkg::PH_TAIL;
        end
      end else if (is_finish) begin
        phase_next     = wmfb_pkg::PH_IDLE;
        remaining_next = '0;
        total_next     = '0;
      end
    end
  end

  // Outputs: the queued command
  always_comb begin
    push      = take && (is_start || is_ssid || is_finish);
    cmd.kind  = frame_kind;
    cmd.rx    = receiver_address;
    cmd.seq   = sequence_value;
    cmd.len   = len_sat;
    cmd.data  = ssid_byte;
    cmd.op    = wmfb_pkg::OP_HEAD;
    cmd.base  = '0;
    if (is_ssid) begin
      cmd.op   = wmfb_pkg::OP_SSID;
      cmd.base = wmfb_pkg::IDX_W'(wmfb_pkg::HEAD_BYTES) + wmfb_pkg::IDX_W'(total)
                 - wmfb_pkg::IDX_W'(remaining);
    end else if (is_finish) begin
      cmd.op   = wmfb_pkg::OP_TAIL;
      cmd.base = wmfb_pkg::IDX_W'(wmfb_pkg::HEAD_BYTES) + wmfb_pkg::IDX_W'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wmfb_pkg::PH_IDLE;
      remaining <= '0;
      total     <= '0;
    end else begin
      phase     <= phase_next;
      remaining <= remaining_next;
      total     <= total_next;
    end
  end

endmodule

// File: design/wmfb_queue.sv
`timescale 1ns / 1ps

// Two-entry command queue between front and back
module wmfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wmfb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wmfb_pkg::cmd_t head_cmd
);

  wmfb_pkg::cmd_t slots [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/wmfb_back.sv
`timescale 1ns / 1ps

// Walks a command byte by byte into the output register
module wmfb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  wmfb_pkg::cmd_t                head_cmd,
  output logic                          pop,
  input  logic [47:0]                   station_address,
  input  logic [63:0]                   beacon_timestamp,
  input  logic [7:0]                    current_channel,
  output logic                          byte_valid,
  input  logic                          byte_stall,
  output logic [7:0]                    frame_byte,
  output logic [wmfb_pkg::IDX_W-1:0]    byte_index,
  output logic                          last_byte,
  output logic [wmfb_pkg::IDX_W-1:0]    frame_length
);

  wmfb_pkg::cmd_t                 cmd;
  logic                           busy;
  logic [wmfb_pkg::CNT_W-1:0]     cnt;
  logic                           advance, final_byte, is_last;
  logic [2:0]                     rx_off, sa_off;
  logic [7:0]                     head_b, out_b;
  logic [wmfb_pkg::IDX_W-1:0]     out_idx, out_len;

  assign advance = busy && (!byte_valid || !byte_stall);
  assign is_last = (cmd.op == wmfb_pkg::OP_TAIL) &&
                   (cnt == wmfb_pkg::CNT_W'(wmfb_pkg::TAIL_LAST));

  always_comb begin
    case (cmd.op)
      wmfb_pkg::OP_HEAD: final_byte = (cnt == wmfb_pkg::CNT_W'(wmfb_pkg::HEAD_LAST));
      wmfb_pkg::OP_SSID: final_byte = 1'b1;
      wmfb_pkg::OP_TAIL: final_byte = is_last;
      default:           final_byte = 1'b1;
    endcase
  end

  assign pop = head_valid && (!busy || (advance && final_byte));

  // Byte offsets within the address fields
  assign rx_off = 3'(cnt - wmfb_pkg::CNT_W'(wmfb_pkg::POS_RX));
  assign sa_off = (cnt < wmfb_pkg::CNT_W'(wmfb_pkg::POS_BSSID)) ?
                  3'(cnt - wmfb_pkg::CNT_W'(wmfb_pkg::POS_SA)) :
                  3'(cnt - wmfb_pkg::CNT_W'(wmfb_pkg::POS_BSSID));

  // Header byte at the current position
  always_comb begin
    case (cnt) inside
      [wmfb_pkg::CNT_W'(wmfb_pkg::POS_RX):wmfb_pkg::CNT_W'(wmfb_pkg::POS_SA - 1)]:
        head_b = cmd.rx[{rx_off, 3'b000} +: 8];
      [wmfb_pkg::CNT_W'(wmfb_pkg::POS_SA):wmfb_pkg::CNT_W'(wmfb_pkg::POS_SEQ_LO - 1)]:
        head_b = station_address[{sa_off, 3'b000} +: 8];
      wmfb_pkg::CNT_W'(wmfb_pkg::POS_SEQ_LO):
        head_b = cmd.seq[7:0];
      wmfb_pkg::CNT_W'(wmfb_pkg::POS_SEQ_HI):
        head_b = cmd.seq[15:8];
      [wmfb_pkg::CNT_W'(wmfb_pkg::POS_TS):wmfb_pkg::CNT_W'(wmfb_pkg::POS_BI - 1)]:
        head_b = beacon_timestamp[{cnt[2:0], 3'b000} +: 8];
      wmfb_pkg::CNT_W'(wmfb_pkg::POS_BI):
        head_b = wmfb_pkg::BEACON_INTERVAL;
      wmfb_pkg::CNT_W'(wmfb_pkg::POS_CAP):
        head_b = wmfb_pkg::CAPABILITY;
      wmfb_pkg::CNT_W'(wmfb_pkg::POS_SSID_LEN):
        head_b = 8'(cmd.len);
      6'd0:
        head_b = cmd.kind ? wmfb_pkg::FT_BEACON : wmfb_pkg::FT_PROBE_RESP;
      default:
        head_b = 8'h00;
    endcase
  end

  // Byte, position and length for the current step
  always_comb begin
    out_len = '0;
    case (cmd.op)
      wmfb_pkg::OP_HEAD: begin
        out_b   = head_b;
        out_idx = wmfb_pkg::IDX_W'(cnt);
      end
      wmfb_pkg::OP_SSID: begin
        out_b   = cmd.data;
        out_idx = cmd.base;
      end
      wmfb_pkg::OP_TAIL: begin
        out_b   = wmfb_pkg::tail_byte(cnt[4:0], current_channel);
        out_idx = cmd.base + wmfb_pkg::IDX_W'(cnt);
        if (is_last) begin
          out_len = cmd.base + wmfb_pkg::IDX_W'(wmfb_pkg::TAIL_BYTES);
        end
      end
      default: begin
        out_b   = 8'h00;
        out_idx = '0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
      if (final_byte) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_byte   <= out_b;
      byte_index   <= out_idx;
      last_byte    <= is_last;
      frame_length <= out_len;
    end
  end

endmodule

// File: design/wifi_mgmt_frame_builder.sv
`timescale 1ns / 1ps
// Path: two-entry queue, back end command register, then the output register.
// Throughput: one byte per cycle at the output while byte_stall is low and work is queued;
// a start makes the byte sequencer emit 38 bytes, an SSID byte one and a finish 29.
// Reset: rst clears phase, queue and output valid; registers return to 0, 0 and channel 4.
module wifi_mgmt_frame_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [1:0]                      func,
  input  logic                            frame_kind,
  input  logic [47:0]                     receiver_address,
  input  logic [15:0]                     sequence_value,
  input  logic [wmfb_pkg::SSID_LEN_W-1:0] ssid_length,
  input  logic [7:0]                      ssid_byte,
  output logic                            byte_valid,
  input  logic                            byte_stall,
  output logic [7:0]                      frame_byte,
  output logic [wmfb_pkg::IDX_W-1:0]      byte_index,
  output logic                            last_byte,
  output logic [wmfb_pkg::IDX_W-1:0]      frame_length
);

`include "wifi_mgmt_frame_builder_defines.svh"

  logic [47:0]    station_address;
  logic [63:0]    beacon_timestamp;
  logic [7:0]     current_channel;
  logic           take, push, q_full, pop, head_valid;
  wmfb_pkg::cmd_t push_cmd, head_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address  <= '0;
      beacon_timestamp <= '0;
      current_channel  <= wmfb_pkg::CHANNEL_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        wmfb_pkg::CFG_STATION:   station_address  <= cfg_data[47:0];
        wmfb_pkg::CFG_TIMESTAMP: beacon_timestamp <= cfg_data;
        wmfb_pkg::CFG_CHANNEL:   current_channel  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign item_stall = q_full;
  assign take       = item_valid && !q_full;

  wmfb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .func             (func),
    .frame_kind       (frame_kind),
    .receiver_address (receiver_address),
    .sequence_value   (sequence_value),
    .ssid_length      (ssid_length),
    .ssid_byte        (ssid_byte),
    .push             (push),
    .cmd              (push_cmd)
  );

  wmfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wmfb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .station_address  (station_address),
    .beacon_timestamp (beacon_timestamp),
    .current_channel  (current_channel),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_byte       (frame_byte),
    .byte_index       (byte_index),
    .last_byte        (last_byte),
    .frame_length     (frame_length)
  );

  // Checks
  `WMFB_ASSERT_NOW(a_last_len, byte_valid && last_byte,
    byte_index == frame_length - 7'd1, "last byte position disagrees with length")
  `WMFB_ASSERT_NOW(a_len_only_last, byte_valid && !last_byte,
    frame_length == 7'd0, "length shown on a byte that is not last")
  `WMFB_ASSERT_NEXT(a_index_step, byte_valid && !byte_stall && !last_byte,
    !byte_valid || (byte_index == $past(byte_index) + 7'd1), "byte position skipped")
  `WMFB_ASSERT_NOW(a_type_byte, byte_valid && (byte_index == 7'd0),
    frame_byte == wmfb_pkg::FT_BEACON || frame_byte == wmfb_pkg::FT_PROBE_RESP,
    "bad frame type byte")

endmodule

// File: dv/wmfb_frame_checker.sv
`timescale 1ns / 1ps

module wmfb_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [1:0]                      cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic [1:0]                      func,
  input  logic                            frame_kind,
  input  logic [47:0]                     receiver_address,
  input  logic [15:0]                     sequence_value,
  input  logic [wmfb_pkg::SSID_LEN_W-1:0] ssid_length,
  input  logic [7:0]                      ssid_byte,
  input  logic                            byte_valid,
  input  logic                            byte_stall,
  input  logic [7:0]                      frame_byte,
  input  logic [wmfb_pkg::IDX_W-1:0]      byte_index,
  input  logic                            last_byte,
  input  logic [wmfb_pkg::IDX_W-1:0]      frame_length,
  output int unsigned                     errors,
  output int unsigned                     pending
);
  import wmfb_pkg::*;

  localparam int unsigned NAME_MAX    = 32;
  localparam int unsigned HDR_LEN     = 38;
  localparam int unsigned TRAILER_LEN = 29;
  localparam int unsigned CHAN_SLOT   = 12;

  localparam logic [7:0] TYPE_PROBE  = 8'h50;
  localparam logic [7:0] TYPE_BEACON = 8'h80;
  localparam logic [7:0] INTERVAL_LO = 8'h64;
  localparam logic [7:0] CAPAB_LO    = 8'h01;
  localparam logic [7:0] NAME_TAG_ID = 8'h00;
  localparam logic [7:0] RESET_CHAN  = 8'h04;

  // Rates, DS parameter, two ERP entries, extended rates
  localparam logic [7:0] TRAILER [TRAILER_LEN] = '{
    8'h01, 8'h08, 8'h02, 8'h04, 8'h0b, 8'h16, 8'h24, 8'h30, 8'h48, 8'h6c,
    8'h03, 8'h01, 8'h00,
    8'h2a, 8'h01, 8'h04, 8'h2f, 8'h01, 8'h04,
    8'h32, 8'h08, 8'h0c, 8'h12, 8'h18, 8'h24, 8'h30, 8'h48, 8'h60, 8'h6c
  };

  typedef struct packed {
    logic [7:0]       value;
    logic [IDX_W-1:0] index;
    logic             last;
    logic [IDX_W-1:0] length;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  // Mirrored registers and frame progress
  logic [47:0]  sta_addr;
  logic [63:0]  tsf_value;
  logic [7:0]   ds_channel;
  phase_t       frame_stage;
  int unsigned  name_left;
  int unsigned  name_count;
  int unsigned  err_count;

  assign errors = err_count;

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic void queue_byte(input logic [7:0] value, input int unsigned index,
                                     input logic last, input int unsigned length);
    frame_byte_t b;
    b.value  = value;
    b.index  = IDX_W'(index);
    b.last   = last;
    b.length = IDX_W'(length);
    expected_bytes.push_back(b);
  endfunction

  // Bytes a request should produce, given the current stage
  task automatic predict_request(input logic [1:0] f, input logic kind,
                                 input logic [47:0] rx, input logic [15:0] seq,
                                 input logic [5:0] len_req, input logic [7:0] name_byte);
    logic [7:0]  hdr [HDR_LEN];
    int unsigned len;
    int unsigned base;
    case (f)
      FUNC_START: begin
        if (frame_stage == PH_IDLE) begin
          // over-long names are clamped, in the length byte too
          len = (len_req > NAME_MAX) ? NAME_MAX : len_req;
          hdr[0] = kind ? TYPE_BEACON : TYPE_PROBE;
          hdr[1] = 8'h00;
          hdr[2] = 8'h00;
          hdr[3] = 8'h00;
          for (int i = 0; i < 6; i++) begin
            hdr[4 + i]  = rx[8*i +: 8];
            hdr[10 + i] = sta_addr[8*i +: 8];
            hdr[16 + i] = sta_addr[8*i +: 8];
          end
          hdr[22] = seq[7:0];
          hdr[23] = seq[15:8];
          for (int i = 0; i < 8; i++) hdr[24 + i] = tsf_value[8*i +: 8];
          hdr[32] = INTERVAL_LO;
          hdr[33] = 8'h00;
          hdr[34] = CAPAB_LO;
          hdr[35] = 8'h00;
          hdr[36] = NAME_TAG_ID;
          hdr[37] = 8'(len);
          for (int i = 0; i < HDR_LEN; i++) queue_byte(hdr[i], i, 1'b0, 0);
          name_count  = len;
          name_left   = len;
          frame_stage = (len == 0) ? PH_TAIL : PH_SSID;
        end
      end
      FUNC_SSID: begin
        if (frame_stage == PH_SSID && name_left != 0) begin
          queue_byte(name_byte, HDR_LEN + name_count - name_left, 1'b0, 0);
          name_left--;
          if (name_left == 0) frame_stage = PH_TAIL;
        end
      end
      FUNC_FINISH: begin
        if (frame_stage == PH_TAIL) begin
          base = HDR_LEN + name_count;
          for (int i = 0; i < TRAILER_LEN; i++) begin
            if (i == TRAILER_LEN - 1)
              queue_byte(TRAILER[i], base + i, 1'b1, base + TRAILER_LEN);
            else if (i == CHAN_SLOT)
              queue_byte(ds_channel, base + i, 1'b0, 0);
            else
              queue_byte(TRAILER[i], base + i, 1'b0, 0);
          end
          frame_stage = PH_IDLE;
          name_left   = 0;
          name_count  = 0;
        end
      end
      default: ;  // unused selector does nothing
    endcase
  endtask

  function automatic void report(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    err_count++;
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      sta_addr    = '0;
      tsf_value   = '0;
      ds_channel  = RESET_CHAN;
      frame_stage = PH_IDLE;
      name_left   = 0;
      name_count  = 0;
      expected_bytes.delete();
    end else begin
      // register writes; an unknown index is dropped
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_STATION:   sta_addr   = cfg_data[47:0];
          CFG_TIMESTAMP: tsf_value  = cfg_data;
          CFG_CHANNEL:   ds_channel = cfg_data[7:0];
          default: ;
        endcase
      end

      if (item_valid && !item_stall)
        predict_request(func, frame_kind, receiver_address, sequence_value,
                        ssid_length, ssid_byte);

      // compare each delivered byte with the oldest prediction
      if (byte_valid && !byte_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t ns: unexpected byte, expected none, actual 0x%0h at index %0d",
                   $time, frame_byte, byte_index);
          err_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (frame_byte !== want.value)    report("frame_byte", want.value, frame_byte);
          if (byte_index !== want.index)    report("byte_index", want.index, byte_index);
          if (last_byte !== want.last)      report("last_byte", want.last, last_byte);
          if (frame_length !== want.length) report("frame_length", want.length, frame_length);
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// File: dv/wifi_mgmt_frame_builder_tb.sv
`timescale 1ns / 1ps

module wifi_mgmt_frame_builder_tb;
  import wmfb_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
  localparam logic [1:0]  CFG_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 130;
  localparam int unsigned NOISE_PCT     = 12;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 2000;

  logic                  clk              = 1'b0;
  logic                  rst              = 1'b1;
  logic                  cfg_write_en     = 1'b0;
  logic [1:0]            cfg_index        = '0;
  logic [63:0]           cfg_data         = '0;
  logic                  item_valid       = 1'b0;
  logic                  item_stall;
  logic [1:0]            func             = '0;
  logic                  frame_kind       = 1'b0;
  logic [47:0]           receiver_address = '0;
  logic [15:0]           sequence_value   = '0;
  logic [SSID_LEN_W-1:0] ssid_length      = '0;
  logic [7:0]            ssid_byte        = '0;
  logic                  byte_valid;
  logic                  byte_stall       = 1'b0;
  logic [7:0]            frame_byte;
  logic [IDX_W-1:0]      byte_index;
  logic                  last_byte;
  logic [IDX_W-1:0]      frame_length;

  int unsigned errors;
  int unsigned pending;
  int unsigned burst_left  = 0;
  int unsigned counted     = 0;
  int unsigned quiet_count = 0;
  int unsigned stall_mode  = 0;
  logic [15:0] stall_tick  = '0;

  wifi_mgmt_frame_builder u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .func             (func),
    .frame_kind       (frame_kind),
    .receiver_address (receiver_address),
    .sequence_value   (sequence_value),
    .ssid_length      (ssid_length),
    .ssid_byte        (ssid_byte),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_byte       (frame_byte),
    .byte_index       (byte_index),
    .last_byte        (last_byte),
    .frame_length     (frame_length)
  );

  wmfb_frame_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .func             (func),
    .frame_kind       (frame_kind),
    .receiver_address (receiver_address),
    .sequence_value   (sequence_value),
    .ssid_length      (ssid_length),
    .ssid_byte        (ssid_byte),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .frame_byte       (frame_byte),
    .byte_index       (byte_index),
    .last_byte        (last_byte),
    .frame_length     (frame_length),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Byte sink: stall style changes every so often
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick % 16'd97 == 16'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       byte_stall <= 1'b0;
      1:       byte_stall <= ($urandom_range(0, 99) < 30);
      2:       byte_stall <= (stall_tick[1:0] == 2'b11);
      default: byte_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (byte_valid && !byte_stall))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count == QUIET_LIMIT) begin
      $display("wifi_mgmt_frame_builder_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Present one request and hold it until taken; bursts with random gaps
  task automatic send_req(input logic [1:0] f, input logic kind, input logic [47:0] rx,
                          input logic [15:0] seq, input logic [5:0] len,
                          input logic [7:0] data);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    item_valid       <= 1'b1;
    func             <= f;
    frame_kind       <= kind;
    receiver_address <= rx;
    sequence_value   <= seq;
    ssid_length      <= len;
    ssid_byte        <= data;
    do @(posedge clk); while (item_stall);
    burst_left--;
  endtask

  // Request with every field but the selector random
  task automatic send_bare(input logic [1:0] f);
    send_req(f, 1'($urandom), rand48(), 16'($urandom), 6'($urandom), 8'($urandom));
  endtask

  // Stop sending and let every predicted byte drain out
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [47:0] sta, input logic [63:0] tsf,
                            input logic [7:0] chan, input bit poke_unused);
    settle();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_STATION;
    cfg_data     <= {16'($urandom), sta};
    @(posedge clk);
    cfg_index    <= CFG_TIMESTAMP;
    cfg_data     <= tsf;
    @(posedge clk);
    cfg_index    <= CFG_CHANNEL;
    cfg_data     <= {$urandom, 24'($urandom), chan};
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  // A request the block should drop in the given stage
  function automatic logic [1:0] ignored_func(input phase_t stage);
    logic [1:0] pick [3];
    case (stage)
      PH_IDLE: pick = '{FUNC_SSID, FUNC_FINISH, FUNC_UNUSED};
      PH_SSID: pick = '{FUNC_START, FUNC_FINISH, FUNC_UNUSED};
      default: pick = '{FUNC_START, FUNC_SSID, FUNC_UNUSED};
    endcase
    return pick[$urandom_range(0, 2)];
  endfunction

  task automatic maybe_noise(input phase_t stage);
    if ($urandom_range(0, 99) < NOISE_PCT) send_bare(ignored_func(stage));
  endtask

  // One well-formed frame with the odd stray request mixed in
  task automatic run_frame(input logic [5:0] len_field);
    int unsigned n_name;
    n_name = (len_field > 6'd32) ? 32 : len_field;
    maybe_noise(PH_IDLE);
    send_req(FUNC_START, 1'($urandom), rand48(), 16'($urandom), len_field, 8'($urandom));
    for (int i = 0; i < n_name; i++) begin
      maybe_noise(PH_SSID);
      send_bare(FUNC_SSID);
    end
    maybe_noise(PH_TAIL);
    send_bare(FUNC_FINISH);
    counted += n_name + 2;
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned r;
    logic [5:0]  len_field;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values first, stray requests in each stage
    send_bare(FUNC_FINISH);
    send_bare(FUNC_SSID);
    send_bare(FUNC_UNUSED);
    send_req(FUNC_START, 1'b0, '1, 16'hffff, 6'd0, 8'hff);      // empty name
    send_req(FUNC_START, 1'b1, rand48(), 16'($urandom), 6'd5, 8'h00);
    send_bare(FUNC_SSID);
    send_bare(FUNC_FINISH);
    send_req(FUNC_START, 1'b1, '0, 16'h0000, 6'd2, 8'h00);
    send_bare(FUNC_FINISH);                                       // too early
    send_req(FUNC_SSID, 1'b0, rand48(), 16'($urandom), 6'd0, 8'h00);
    send_req(FUNC_SSID, 1'b1, rand48(), 16'($urandom), 6'd63, 8'hff);
    send_bare(FUNC_SSID);                                         // one too many
    send_bare(FUNC_FINISH);

    // Registers at their top values, plus a write to the unused index
    write_regs('1, '1, 8'hff, 1'b1);
    send_req(FUNC_START, 1'b1, 48'h0123_4567_89ab, 16'h00ff, 6'd1, 8'h00);
    send_req(FUNC_SSID, 1'b0, '0, '0, '0, 8'ha5);
    send_bare(FUNC_FINISH);

    write_regs('0, '0, 8'h00, 1'b0);
    send_req(FUNC_START, 1'b0, 48'h8000_0000_0001, 16'h8001, 6'd0, 8'h00);
    send_bare(FUNC_FINISH);
    write_regs(rand48(), {$urandom, $urandom}, 8'($urandom), 1'b0);

    // Random frames; clamped name lengths come first
    frame_no = 0;
    while (counted < RANDOM_ITEMS) begin
      case (frame_no)
        0: len_field = 6'd33;
        1: len_field = 6'd63;
        2: len_field = 6'd32;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 60)      len_field = 6'($urandom_range(0, 6));
          else if (r < 85) len_field = 6'($urandom_range(7, 32));
          else             len_field = 6'($urandom_range(33, 63));
        end
      endcase
      run_frame(len_field);
      r = $urandom_range(0, 99);
      if (r < 5)
        write_regs('1, '1, 8'hff, 1'b1);
      else if (r < 10)
        write_regs('0, '0, 8'h00, 1'b0);
      else if (r < 18)
        write_regs(rand48(), {$urandom, $urandom}, 8'($urandom), $urandom_range(0, 1));
      else if (r < 28)
        settle();
      frame_no++;
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("wifi_mgmt_frame_builder_tb: PASS");
    end else begin
      $display("wifi_mgmt_frame_builder_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/wmfb_pkg.sv
design/wmfb_front.sv
design/wmfb_queue.sv
design/wmfb_back.sv
design/wifi_mgmt_frame_builder.sv
dv/wmfb_frame_checker.sv
dv/wifi_mgmt_frame_builder_tb.sv
